/* hw/rtl/wordlist_suffix_enumerator_unit_macros.svh */
// Assertion macros used by the checker file of the suffix enumerator.
`ifndef WORDLIST_SUFFIX_ENUMERATOR_UNIT_MACROS_SVH
`define WORDLIST_SUFFIX_ENUMERATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/wse_pkg.sv */
// Types and constants shared by the suffix enumerator modules.
package wse_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_CHARSET_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHARSET_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHARSET_SIZE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LEN      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN      = 3'd4;

  localparam logic [63:0] CHARSET_LOW_RST  = 64'd3978425819141910832;
  localparam logic [63:0] CHARSET_HIGH_RST = 64'd14648;
  localparam logic [4:0]  CHARSET_SIZE_RST = 5'd10;
  localparam logic [3:0]  MIN_LEN_RST      = 4'd1;
  localparam logic [3:0]  MAX_LEN_RST      = 4'd4;

  // Widest suffix the result field can describe.
  localparam logic [3:0] SUFFIX_LEN_LIMIT = 4'd8;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_NEXT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] word_tag;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_tag;
    logic [63:0] suffix_chars;
    logic [3:0]  suffix_len;
    logic        valid_res;
    logic        need_word;
    logic [63:0] generated_count;
  } out_item_t;

  typedef struct packed {
    logic [63:0] charset_low;
    logic [63:0] charset_high;
    logic [4:0]  charset_size;
    logic [3:0]  min_len;
    logic [3:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic        word_loaded;
    logic        length_done;
    logic [3:0]  cur_len;
    logic [31:0] tag;
    logic [63:0] count;
  } enum_state_t;

endpackage

/* hw/rtl/wse_cfg_regs.sv */
// Configuration register file of the suffix enumerator.
module wse_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wse_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                 cfg_wdata_i,
  output wse_pkg::cfg_t               cfg_o
);

  wse_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charset_low  <= wse_pkg::CHARSET_LOW_RST;
      cfg_q.charset_high <= wse_pkg::CHARSET_HIGH_RST;
      cfg_q.charset_size <= wse_pkg::CHARSET_SIZE_RST;
      cfg_q.min_len      <= wse_pkg::MIN_LEN_RST;
      cfg_q.max_len      <= wse_pkg::MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wse_pkg::CFG_CHARSET_LOW:  cfg_q.charset_low  <= cfg_wdata_i;
        wse_pkg::CFG_CHARSET_HIGH: cfg_q.charset_high <= cfg_wdata_i;
        wse_pkg::CFG_CHARSET_SIZE: cfg_q.charset_size <= cfg_wdata_i[4:0];
        wse_pkg::CFG_MIN_LEN:      cfg_q.min_len      <= cfg_wdata_i[3:0];
        wse_pkg::CFG_MAX_LEN:      cfg_q.max_len      <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/wse_step.sv */
// Combinational step: odometer increment, character mapping and word control.
module wse_step #(
  parameter int unsigned MaxSuffixLen = 8,
  parameter int unsigned CharsetMax   = 16
) (
  input  wse_pkg::cfg_t                      cfg_i,
  input  wse_pkg::in_item_t                  item_i,
  input  wse_pkg::enum_state_t               st_i,
  input  logic [MaxSuffixLen-1:0][3:0]       digits_i,
  output wse_pkg::enum_state_t               st_o,
  output logic [MaxSuffixLen-1:0][3:0]       digits_o,
  output wse_pkg::out_item_t                 result_o
);

  localparam logic [3:0] MaxLen  = 4'(MaxSuffixLen);
  localparam logic [4:0] SizeMax = 5'(CharsetMax);

  logic [3:0]                   min_len;
  logic [3:0]                   max_len;
  logic [3:0]                   work_len;
  logic [4:0]                   size;
  logic [MaxSuffixLen-1:0][3:0] work_dig;
  logic [MaxSuffixLen-1:0][3:0] inc_dig;
  logic [MaxSuffixLen-1:0]      sat;
  logic [MaxSuffixLen-1:0]      cin;
  logic                         carry_out;
  logic [63:0]                  chars;
  logic [127:0]                 charset;

  assign min_len = (cfg_i.min_len > MaxLen) ? MaxLen : cfg_i.min_len;
  assign max_len = (cfg_i.max_len > MaxLen) ? MaxLen : cfg_i.max_len;

  always_comb begin
    if (cfg_i.charset_size == 5'd0) begin
      size = 5'd1;
    end else if (cfg_i.charset_size > SizeMax) begin
      size = SizeMax;
    end else begin
      size = cfg_i.charset_size;
    end
  end

  // A finished length moves on to the next one with all digits back at zero.
  assign work_len = st_i.length_done ? st_i.cur_len + 4'd1 : st_i.cur_len;
  assign work_dig = st_i.length_done ? '0 : digits_i;
  assign charset  = {cfg_i.charset_high, cfg_i.charset_low};

  // The highest-indexed used digit always takes the increment; the carry ripples
  // towards digit zero past every digit that wraps.
  always_comb begin
    logic c;
    c = 1'b1;
    for (int i = MaxSuffixLen - 1; i >= 0; i--) begin
      sat[i] = ({1'b0, work_dig[i]} + 5'd1) >= size;
      if (4'(i) < work_len) begin
        cin[i] = c;
        c      = c & sat[i];
      end else begin
        cin[i] = 1'b0;
      end
      if (cin[i]) begin
        inc_dig[i] = sat[i] ? 4'd0 : work_dig[i] + 4'd1;
      end else begin
        inc_dig[i] = work_dig[i];
      end
    end
    carry_out = c;
  end

  always_comb begin
    chars = '0;
    for (int i = 0; i < MaxSuffixLen; i++) begin
      if (4'(i) < work_len) begin
        chars[8*i +: 8] = charset[{work_dig[i], 3'b000} +: 8];
      end
    end
  end

  always_comb begin
    st_o     = st_i;
    digits_o = digits_i;
    result_o = '0;
    if (item_i.action == wse_pkg::ACT_LOAD) begin
      st_o.tag         = item_i.word_tag;
      st_o.word_loaded = 1'b1;
      st_o.length_done = 1'b0;
      st_o.cur_len     = min_len;
      digits_o         = '0;
    end else if (!st_i.word_loaded) begin
      result_o.need_word = 1'b1;
    end else if (work_len > max_len) begin
      st_o.word_loaded   = 1'b0;
      st_o.length_done   = 1'b1;
      st_o.cur_len       = work_len;
      digits_o           = work_dig;
      result_o.need_word = 1'b1;
    end else begin
      st_o.cur_len          = work_len;
      st_o.length_done      = carry_out;
      st_o.count            = st_i.count + 64'd1;
      digits_o              = inc_dig;
      result_o.valid_res    = 1'b1;
      result_o.suffix_len   = work_len;
      result_o.suffix_chars = chars;
    end
    result_o.out_tag         = st_o.tag;
    result_o.generated_count = st_o.count;
  end

endmodule

/* hw/rtl/wordlist_suffix_enumerator_unit.sv */
// A transaction waits in the input register, then its result goes to the result register.
// Throughput: one transaction per cycle unless the output stalls; the odometer carry over
// all digits is one combinational step between the input and result registers.
// Reset (async, active low) clears the word state, digits, candidate count and
// registers to their documented defaults; no clearing pass is needed.
module wordlist_suffix_enumerator_unit #(
  parameter int unsigned MAX_SUFFIX_LEN = 8,
  parameter int unsigned CHARSET_MAX    = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wse_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  wse_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output wse_pkg::out_item_t          out_item_o
);

  wse_pkg::cfg_t                  cfg;
  wse_pkg::in_item_t              in_item_q;
  logic                           in_valid_q;
  wse_pkg::out_item_t             out_item_q;
  wse_pkg::out_item_t             result_d;
  logic                           out_valid_q;
  wse_pkg::enum_state_t           st_q;
  wse_pkg::enum_state_t           st_d;
  logic [MAX_SUFFIX_LEN-1:0][3:0] digits_q;
  logic [MAX_SUFFIX_LEN-1:0][3:0] digits_d;
  logic                           advance;
  logic                           in_accept;

  wse_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wse_step #(
    .MaxSuffixLen (MAX_SUFFIX_LEN),
    .CharsetMax   (CHARSET_MAX)
  ) u_step (
    .cfg_i    (cfg),
    .item_i   (in_item_q),
    .st_i     (st_q),
    .digits_i (digits_q),
    .st_o     (st_d),
    .digits_o (digits_d),
    .result_o (result_d)
  );

  // The held transaction moves on whenever the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{word_loaded: 1'b0, length_done: 1'b1, cur_len: 4'd0,
                       tag: 32'd0, count: 64'd0};
      digits_q    <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
        digits_q    <= digits_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* hw/rtl/wse_checker.sv */
// Port-level checks for the suffix enumerator, bound to the top level.
`include "wordlist_suffix_enumerator_unit_macros.svh"

module wse_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [wse_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [63:0]                 cfg_wdata_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input wse_pkg::in_item_t           in_item_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input wse_pkg::out_item_t          out_item_o
);

  // A candidate never asks for a new word and never exceeds the widest suffix.
  `WSE_ASSERT_IMPL(a_cand_shape, out_valid_o && out_item_o.valid_res, !out_item_o.need_word && (out_item_o.suffix_len <= wse_pkg::SUFFIX_LEN_LIMIT), "candidate result malformed")

  // A transaction without a candidate carries an empty suffix.
  `WSE_ASSERT_IMPL(a_empty_suffix, out_valid_o && !out_item_o.valid_res, (out_item_o.suffix_chars == 64'd0) && (out_item_o.suffix_len == 4'd0), "non-candidate carries suffix data")

  // The input side only backs up when the result register is held.
  `WSE_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without output back-pressure")

  // A stalled result stays in place.
  `WSE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result changed")

endmodule

bind wordlist_suffix_enumerator_unit wse_checker u_wse_checker (.*);
